/* rtl/core/pgd_pkg.sv */
package pgd_pkg;

  // Command codes carried by an input request.
  localparam logic [1:0] CMD_REPORT = 2'd0;
  localparam logic [1:0] CMD_LAYER  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // Direction sectors, clockwise from east with y pointing down.
  localparam logic [2:0] DIR_E  = 3'd0;
  localparam logic [2:0] DIR_SE = 3'd1;
  localparam logic [2:0] DIR_S  = 3'd2;
  localparam logic [2:0] DIR_SW = 3'd3;
  localparam logic [2:0] DIR_W  = 3'd4;

  // Sector boundary tangents in unsigned Q32, rounded to nearest.
  localparam int TAN_W = 34;
  localparam logic [TAN_W-1:0] TAN22 = 34'd1735279427;
  localparam logic [TAN_W-1:0] TAN23 = 34'd1823105454;
  localparam logic [TAN_W-1:0] TAN67 = 34'd10118308865;
  localparam logic [TAN_W-1:0] TAN68 = 34'd10630417090;

  // Width of one slice of a magnitude fed to a tangent multiplier.
  localparam int PIECE_W = 16;

  // Reset value of the minimum gesture distance register.
  localparam logic [15:0] MIN_DIST_RESET = 16'd500;

  // Queue between the front and the back part.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // Motion and wheel fields passed through to the result.
  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [7:0]  out_v;
    logic signed [7:0]  out_h;
  } rpt_t;

endpackage

/* rtl/core/pgd_if.sv */
interface pgd_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [15:0] dx;
  logic signed [15:0] dy;
  logic signed [7:0] dv;
  logic signed [7:0] dh;
  logic              in_gesture_layer;
  logic              raise_held;

  modport source (
    output valid, cmd, dx, dy, dv, dh, in_gesture_layer, raise_held,
    input  ready
  );
  modport sink (
    input  valid, cmd, dx, dy, dv, dh, in_gesture_layer, raise_held,
    output ready
  );
endinterface

interface pgd_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [7:0] out_v;
  logic signed [7:0] out_h;
  logic              gesture_fire;
  logic [2:0]        direction;

  modport source (
    output valid, out_x, out_y, out_v, out_h, gesture_fire, direction,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_v, out_h, gesture_fire, direction,
    output ready
  );
endinterface

/* rtl/core/pgd_front.sv */
module pgd_front
  import pgd_pkg::*;
#(
  parameter int SUM_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  pgd_in_if.sink                      items,
  input  logic                        q_full,
  output logic                        push,
  output rpt_t                        push_rpt,
  output logic                        push_resolve,
  output logic signed [SUM_WIDTH-1:0] push_sx,
  output logic signed [SUM_WIDTH-1:0] push_sy
);

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic signed [SUM_WIDTH-1:0] sum_x;
  logic signed [SUM_WIDTH-1:0] sum_y;
  logic                        gesture_held;
  logic                        gesture_done;
  logic signed [SUM_WIDTH:0]   add_x;
  logic signed [SUM_WIDTH:0]   add_y;
  logic                        resolve;

  // Clamp a one-bit-wider sum back to the accumulator range.
  function automatic logic signed [SUM_WIDTH-1:0] sat(input logic signed [SUM_WIDTH:0] v);
    if (v[SUM_WIDTH] != v[SUM_WIDTH-1]) begin
      return v[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end
    return v[SUM_WIDTH-1:0];
  endfunction

  // A request is taken whenever the queue has room.
  assign items.ready = !q_full;
  assign push        = items.valid && !q_full;

  // Sign-extended sums of the accumulators and the report motion.
  assign add_x = {sum_x[SUM_WIDTH-1], sum_x} + {{(SUM_WIDTH-15){items.dx[15]}}, items.dx};
  assign add_y = {sum_y[SUM_WIDTH-1], sum_y} + {{(SUM_WIDTH-15){items.dy[15]}}, items.dy};

  // A tick resolves a gesture that was armed and whose layer has been left.
  assign resolve = (items.cmd == CMD_TICK) && !gesture_held && !gesture_done;

  // Job handed to the back part: masked report fields and the sums as they stand.
  always_comb begin
    push_rpt = '0;
    if (items.cmd == CMD_REPORT && !items.raise_held) begin
      push_rpt.out_x = items.dx;
      push_rpt.out_y = items.dy;
      push_rpt.out_v = items.dv;
      push_rpt.out_h = items.dh;
    end
  end
  assign push_resolve = resolve;
  assign push_sx      = sum_x;
  assign push_sy      = sum_y;

  // Gesture state, updated once per accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x        <= '0;
      sum_y        <= '0;
      gesture_held <= 1'b0;
      gesture_done <= 1'b1;
    end else if (push) begin
      unique case (items.cmd)
        CMD_REPORT: begin
          if (items.in_gesture_layer) begin
            sum_x <= sat(add_x);
            sum_y <= sat(add_y);
          end
        end
        CMD_LAYER: begin
          if (items.in_gesture_layer) begin
            sum_x        <= '0;
            sum_y        <= '0;
            gesture_held <= 1'b1;
            gesture_done <= 1'b0;
          end else begin
            gesture_held <= 1'b0;
          end
        end
        CMD_TICK: begin
          if (resolve) begin
            gesture_done <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/pgd_queue.sv */
module pgd_queue
  import pgd_pkg::*;
#(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output logic [DATA_W-1:0] head_data
);

  logic [DATA_W-1:0]  slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;

  assign full      = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty     = (count == '0);
  assign head_data = slots[rd_ptr];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/pgd_back.sv */
module pgd_back
  import pgd_pkg::*;
#(
  parameter int SUM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        q_empty,
  input  logic [$bits(rpt_t)+2*SUM_WIDTH:0] q_head,
  output logic        q_pop,
  pgd_out_if.source   results
);

  localparam int NCH  = (SUM_WIDTH + PIECE_W - 1) / PIECE_W;
  localparam int APW  = NCH * PIECE_W;
  localparam int PP_W = PIECE_W + TAN_W;
  localparam int PW   = APW + TAN_W;

  logic [15:0] min_dist;

  // Queue head fields.
  rpt_t                        h_rpt;
  logic                        h_res;
  logic signed [SUM_WIDTH-1:0] h_sx;
  logic signed [SUM_WIDTH-1:0] h_sy;
  logic [SUM_WIDTH:0]          h_ax;
  logic [SUM_WIDTH:0]          h_ay;

  logic adv;

  // Stage 1: magnitudes and signs.
  logic                 s1_valid;
  rpt_t                 s1_rpt;
  logic                 s1_res;
  logic [SUM_WIDTH-1:0] s1_ax;
  logic [SUM_WIDTH-1:0] s1_ay;
  logic                 s1_xneg;
  logic                 s1_yneg;
  logic                 s1_xzero;
  logic                 s1_yzero;
  logic                 s1_big;

  // Stage 2: partial products and squares.
  logic [APW-1:0]       s1_axp;
  logic [TAN_W-1:0]     t_lo;
  logic [TAN_W-1:0]     t_hi;
  logic [PP_W-1:0]      pl [NCH];
  logic [PP_W-1:0]      ph [NCH];
  logic                 s2_valid;
  rpt_t                 s2_rpt;
  logic                 s2_res;
  logic [SUM_WIDTH-1:0] s2_ay;
  logic                 s2_xneg;
  logic                 s2_yneg;
  logic                 s2_xzero;
  logic                 s2_yzero;
  logic                 s2_big;
  logic [PP_W-1:0]      s2_pl [NCH];
  logic [PP_W-1:0]      s2_ph [NCH];
  logic [31:0]          s2_sqx;
  logic [31:0]          s2_sqy;
  logic [31:0]          s2_sqd;

  // Stage 3: full tangent products and the distance test.
  logic [PW-1:0]        prod_lo;
  logic [PW-1:0]        prod_hi;
  logic                 s3_valid;
  rpt_t                 s3_rpt;
  logic                 s3_res;
  logic [SUM_WIDTH-1:0] s3_ay;
  logic                 s3_xneg;
  logic                 s3_yneg;
  logic                 s3_xzero;
  logic                 s3_yzero;
  logic                 s3_long;
  logic [PW-1:0]        s3_prod_lo;
  logic [PW-1:0]        s3_prod_hi;

  // Output stage: boundary compares and sector.
  logic [PW-1:0] ay_sh;
  logic          ge_lo;
  logic          ge_hi;
  logic          le_lo;
  logic          le_hi;
  logic [2:0]    sect;
  logic [2:0]    sect_half;

  // Minimum distance register.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= MIN_DIST_RESET;
    end else if (cfg_we) begin
      min_dist <= cfg_wdata;
    end
  end

  // The whole pipe moves unless a finished result is stalled.
  assign adv   = !results.valid || results.ready;
  assign q_pop = adv && !q_empty;

  // Unpack the head of the queue and take magnitudes.
  assign {h_rpt, h_res, h_sx, h_sy} = q_head;
  assign h_ax = h_sx[SUM_WIDTH-1] ? ({1'b0, ~h_sx} + 1'b1) : {1'b0, h_sx};
  assign h_ay = h_sy[SUM_WIDTH-1] ? ({1'b0, ~h_sy} + 1'b1) : {1'b0, h_sy};

  // Tangent pair depends on the half plane of x.
  assign s1_axp = APW'(s1_ax);
  assign t_lo   = s1_xneg ? TAN22 : TAN23;
  assign t_hi   = s1_xneg ? TAN67 : TAN68;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      pl[i] = s1_axp[i*PIECE_W +: PIECE_W] * t_lo;
      ph[i] = s1_axp[i*PIECE_W +: PIECE_W] * t_hi;
    end
  end

  // Recombine the slices into full products.
  always_comb begin
    prod_lo = '0;
    prod_hi = '0;
    for (int i = 0; i < NCH; i++) begin
      prod_lo = prod_lo + (PW'(s2_pl[i]) << (i * PIECE_W));
      prod_hi = prod_hi + (PW'(s2_ph[i]) << (i * PIECE_W));
    end
  end

  // Compare |y| * 2^32 against |x| * tan for both boundaries.
  assign ay_sh = PW'(s3_ay) << 32;
  assign ge_lo = ay_sh >= s3_prod_lo;
  assign ge_hi = ay_sh >= s3_prod_hi;
  assign le_lo = ay_sh <= s3_prod_lo;
  assign le_hi = ay_sh <= s3_prod_hi;

  // Sector in the lower half plane, then mirrored for negative y.
  always_comb begin
    priority if (s3_xzero && s3_yzero) begin
      sect_half = DIR_E;
    end else if (s3_xzero) begin
      sect_half = DIR_S;
    end else if (!s3_xneg) begin
      sect_half = ge_hi ? DIR_S : (ge_lo ? DIR_SE : DIR_E);
    end else begin
      sect_half = le_lo ? DIR_W : (le_hi ? DIR_SW : DIR_S);
    end
    sect = s3_yneg ? (DIR_E - sect_half) : sect_half;
  end

  // Valid bits of the pipe and of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      s3_valid      <= 1'b0;
      results.valid <= 1'b0;
    end else if (adv) begin
      s1_valid      <= q_pop;
      s2_valid      <= s1_valid;
      s3_valid      <= s2_valid;
      results.valid <= s3_valid;
    end
  end

  // Payload of the pipe stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rpt   <= h_rpt;
      s1_res   <= h_res;
      s1_ax    <= h_ax[SUM_WIDTH-1:0];
      s1_ay    <= h_ay[SUM_WIDTH-1:0];
      s1_xneg  <= h_sx[SUM_WIDTH-1];
      s1_yneg  <= h_sy[SUM_WIDTH-1];
      s1_xzero <= (h_sx == '0);
      s1_yzero <= (h_sy == '0);
      s1_big   <= (|h_ax[SUM_WIDTH:16]) || (|h_ay[SUM_WIDTH:16]);

      s2_rpt   <= s1_rpt;
      s2_res   <= s1_res;
      s2_ay    <= s1_ay;
      s2_xneg  <= s1_xneg;
      s2_yneg  <= s1_yneg;
      s2_xzero <= s1_xzero;
      s2_yzero <= s1_yzero;
      s2_big   <= s1_big;
      s2_pl    <= pl;
      s2_ph    <= ph;
      s2_sqx   <= s1_ax[15:0] * s1_ax[15:0];
      s2_sqy   <= s1_ay[15:0] * s1_ay[15:0];
      s2_sqd   <= min_dist * min_dist;

      s3_rpt     <= s2_rpt;
      s3_res     <= s2_res;
      s3_ay      <= s2_ay;
      s3_xneg    <= s2_xneg;
      s3_yneg    <= s2_yneg;
      s3_xzero   <= s2_xzero;
      s3_yzero   <= s2_yzero;
      s3_long    <= s2_big || (({1'b0, s2_sqx} + {1'b0, s2_sqy}) >= {1'b0, s2_sqd});
      s3_prod_lo <= prod_lo;
      s3_prod_hi <= prod_hi;

      results.out_x        <= s3_rpt.out_x;
      results.out_y        <= s3_rpt.out_y;
      results.out_v        <= s3_rpt.out_v;
      results.out_h        <= s3_rpt.out_h;
      results.gesture_fire <= s3_res && s3_long;
      results.direction    <= (s3_res && s3_long) ? sect : DIR_E;
    end
  end

endmodule

/* rtl/core/pointer_gesture_direction_classifier.sv */
// An accepted request is queued, then passes registers s1, s2, s3 and the output.
// Throughput: one request per cycle; the four-entry queue and the pipe of the
// classifier carry back-to-back requests while the result side keeps up.
// A stalled result freezes the classifier pipe; the queue then fills and drops ready.
// Reset (rst, synchronous, active high) clears the sums, disarms the gesture,
// empties the queue and sets the minimum distance to 500.
module pointer_gesture_direction_classifier
  import pgd_pkg::*;
#(
  parameter int SUM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  pgd_in_if.sink      items,
  pgd_out_if.source   results
);

  localparam int DATA_W = $bits(rpt_t) + 1 + 2 * SUM_WIDTH;

  logic                        push;
  rpt_t                        push_rpt;
  logic                        push_resolve;
  logic signed [SUM_WIDTH-1:0] push_sx;
  logic signed [SUM_WIDTH-1:0] push_sy;
  logic                        q_full;
  logic                        q_empty;
  logic                        q_pop;
  logic [DATA_W-1:0]           q_head;

  // Front part: takes requests and keeps the gesture state.
  pgd_front #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .items        (items),
    .q_full       (q_full),
    .push         (push),
    .push_rpt     (push_rpt),
    .push_resolve (push_resolve),
    .push_sx      (push_sx),
    .push_sy      (push_sy)
  );

  // Short queue between the two parts.
  pgd_queue #(
    .DATA_W(DATA_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_rpt, push_resolve, push_sx, push_sy}),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_data (q_head)
  );

  // Back part: distance test, direction sector and the result register.
  pgd_back #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .results   (results)
  );

endmodule

/* rtl/core/pgd_checker.sv */
module pgd_checker
  import pgd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [7:0] out_v,
  input logic signed [7:0] out_h,
  input logic              gesture_fire,
  input logic [2:0]        direction
);

  // Nothing leaves the block in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A resolved gesture comes from a tick, which carries no motion.
  a_fire_no_motion: assert property (@(posedge clk) disable iff (rst)
    out_valid && gesture_fire |-> out_x == 0 && out_y == 0 && out_v == 0 && out_h == 0)
    else $error("gesture result carries motion");

  // Without a gesture the direction reads as zero.
  a_dir_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !gesture_fire |-> direction == DIR_E)
    else $error("direction set without a gesture");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_x, out_y, out_v, out_h, gesture_fire, direction}))
    else $error("stalled result changed");

endmodule

bind pointer_gesture_direction_classifier pgd_checker u_pgd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (results.valid),
  .out_ready    (results.ready),
  .out_x        (results.out_x),
  .out_y        (results.out_y),
  .out_v        (results.out_v),
  .out_h        (results.out_h),
  .gesture_fire (results.gesture_fire),
  .direction    (results.direction)
);
